### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PWG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Trigger in one cycle, consequence checked in the next.
`define PWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pwg_pkg.sv
package pwg_pkg;

	typedef enum logic [2:0] {
		MODE_ZERO     = 3'd0,
		MODE_SINE     = 3'd1,
		MODE_COSINE   = 3'd2,
		MODE_SQUARE   = 3'd3,
		MODE_RAMP     = 3'd4,
		MODE_TRIANGLE = 3'd5
	} wave_mode_t;

	typedef enum logic [1:0] {
		CFG_WAVE_MODE      = 2'd0,
		CFG_PEAK_AMPLITUDE = 2'd1,
		CFG_DC_OFFSET      = 2'd2
	} cfg_index_t;

	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int MODE_W       = 3;
	localparam int AMP_W        = 15;
	localparam int OFFSET_W     = 16;
	localparam int SAMPLE_W     = 17;
	localparam int PHASE_OUT_W  = 6;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 24;

	// Q2.30 fixed point used by the table builder and the reciprocal divide
	localparam int          Q30_SHIFT    = 30;
	localparam logic [63:0] ONE_Q30      = 64'd1 << Q30_SHIFT;
	localparam logic [63:0] PI_Q30       = 64'd3373259426;
	localparam int          SERIES_TERMS = 6;
	localparam logic [7:0]  SERIES_DIV [SERIES_TERMS] = '{
		8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
	};

endpackage

### hdl/pwg_sine_rom.sv
module pwg_sine_rom #(
	parameter int PHASE_STEPS = 64,
	parameter int SINE_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic [$clog2(PHASE_STEPS + 1)-1:0]   rd_addr,
	output logic [SINE_BITS-2:0]                 rd_data
);
	import pwg_pkg::*;

	localparam int          DEPTH     = PHASE_STEPS + 1;
	localparam logic [63:0] HALF_TURN = 64'(2 * PHASE_STEPS);

	typedef logic [SINE_BITS-2:0] rom_t [DEPTH];

	// quarter wave, sin(pi*q/(2N)) for q = 0..N, rounded, clipped to full scale
	function automatic logic [SINE_BITS-2:0] sine_mag(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] m;
		logic [63:0] lim;
		logic [2:0]  i;
		x  = (PI_Q30 * 64'(q)) / HALF_TURN;
		x2 = (x * x) >> Q30_SHIFT;
		t  = ONE_Q30;
		for (i = 3'd0; i < 3'(SERIES_TERMS); i++) begin
			t = ONE_Q30 - ((x2 * t) >> Q30_SHIFT) / 64'(SERIES_DIV[i]);
		end
		s   = (x * t) >> Q30_SHIFT;
		m   = (s + (64'd1 << (Q30_SHIFT - SINE_BITS))) >> (Q30_SHIFT + 1 - SINE_BITS);
		lim = (64'd1 << (SINE_BITS - 1)) - 64'd1;
		if (m > lim) begin
			m = lim;
		end
		return m[SINE_BITS-2:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int unsigned q = 0; q < DEPTH; q++) begin
			r[q] = sine_mag(q);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= SINE_ROM[rd_addr];
		end
	end

endmodule

### hdl/periodic_waveform_generator_core.sv
// Periodic waveform generator, one signed sample per accepted tick.
// Input stream s_*: each transfer is one tick; s_tdata[0] = restart, which
// forces phase 0 for that tick. Output stream m_*: one transfer per tick,
// m_tdata = sample (17b signed) then phase index (6b), m_tlast marks the last
// phase of a cycle. Config channel cfg_*: index 0 mode, 1 amplitude,
// 2 offset; other indexes are dropped. cfg_ready is always high; write only
// while no tick is in flight.
// Throughput: one tick per clock while m_tready does not stall the output. A
// tick passes through five pipeline stages plus the output register. The
// one-port sine ROM is read once per tick, and the truncating divide by
// PHASE_STEPS is a reciprocal multiply, back-multiply and one correction
// spread over three stages.
// When m_tready is low the output register holds and the stages behind it
// keep filling, so up to six ticks are taken before s_tready drops.
// Reset clears the phase, the mode, amplitude and offset registers and all
// stage valids; the sine table is a constant ROM and needs no fill.
`include "assert_macros.svh"

module periodic_waveform_generator_core #(
	parameter int PHASE_STEPS = 64,
	parameter int SINE_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [pwg_pkg::IN_TDATA_W-1:0]        s_tdata,   // [0] restart
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [pwg_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [16:0] sample, [22:17] phase_index
	output logic                                  m_tlast,   // cycle_end
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pwg_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [pwg_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pwg_pkg::*;

	localparam int PW   = $clog2(PHASE_STEPS);
	localparam int AW   = $clog2(PHASE_STEPS + 1);
	localparam int QW   = AW + 3;
	localparam int KCW  = AW + 3;
	localparam int KW   = AW + 1;
	localparam int OW   = (SINE_BITS > KW) ? SINE_BITS : KW;
	localparam int MW   = OFFSET_W + OW;
	localparam int YW   = OFFSET_W + 1 + AW;
	localparam int XW   = YW - 1;
	localparam int RW   = Q30_SHIFT + 1;
	localparam int PRW  = XW + RW;
	localparam int QAW  = 16;

	localparam logic [PW-1:0]         PHASE_LAST = PW'(PHASE_STEPS - 1);
	localparam logic [PW-1:0]         PHASE_ONE  = PW'(1);
	localparam logic [QW-1:0]         N_Q        = QW'(PHASE_STEPS);
	localparam logic [QW-1:0]         TWO_N_Q    = QW'(2 * PHASE_STEPS);
	localparam logic [QW-1:0]         FOUR_N_Q   = QW'(4 * PHASE_STEPS);
	localparam logic signed [KCW-1:0] N_K        = KCW'(PHASE_STEPS);
	localparam logic signed [KCW-1:0] THREE_N_K  = KCW'(3 * PHASE_STEPS);
	localparam logic signed [YW-1:0]  N_Y        = YW'(PHASE_STEPS);
	localparam logic [XW-1:0]         N_X        = XW'(PHASE_STEPS);
	localparam logic [RW-1:0]         RECIP      = RW'((64'd1 << Q30_SHIFT) / PHASE_STEPS);

	// configuration
	wave_mode_t                   mode_q;
	logic [AMP_W-1:0]             amp_q;
	logic signed [OFFSET_W-1:0]   off_q;
	logic signed [YW-1:0]         on_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ZERO;
			amp_q  <= '0;
			off_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WAVE_MODE:      mode_q <= wave_mode_t'(cfg_data[MODE_W-1:0]);
				CFG_PEAK_AMPLITUDE: amp_q  <= cfg_data[AMP_W-1:0];
				CFG_DC_OFFSET:      off_q  <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// offset scaled by N for the ramp and triangle numerators
	always_ff @(posedge clk) begin
		on_q <= YW'(off_q) * N_Y;
	end

	// stage enables, bubbles collapse
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic en1, en2, en3, en4, en5, en_o;
	logic accept;

	assign en_o     = !out_v_q || m_tready;
	assign en5      = !v_s5 || en_o;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;

	// stage 0: phase, table address, ramp and triangle slope term, square half
	logic [PW-1:0]         phase_q;
	logic [PW-1:0]         p_cur;
	logic [QW-1:0]         q_fold;
	logic                  neg_d;
	logic [AW-1:0]         rom_addr;
	logic signed [KCW-1:0] p_k;
	logic signed [KCW-1:0] k_d;
	logic                  sq_hi_d;

	assign p_cur = s_tdata[0] ? '0 : phase_q;

	always_comb begin
		q_fold = QW'(p_cur) << 2;
		if (mode_q == MODE_COSINE) begin
			q_fold = q_fold + N_Q;
		end
		if (q_fold >= FOUR_N_Q) begin
			q_fold = q_fold - FOUR_N_Q;
		end
		neg_d = 1'b0;
		if (q_fold >= TWO_N_Q) begin
			q_fold = q_fold - TWO_N_Q;
			neg_d  = 1'b1;
		end
		if (q_fold > N_Q) begin
			q_fold = TWO_N_Q - q_fold;
		end
		rom_addr = AW'(q_fold);
	end

	always_comb begin
		p_k     = KCW'(p_cur);
		sq_hi_d = (p_k <<< 1) <= N_K;
		if (mode_q == MODE_RAMP) begin
			k_d = (p_k <<< 1) - N_K;
		end else if (sq_hi_d) begin
			k_d = (p_k <<< 2) - N_K;
		end else begin
			k_d = THREE_N_K - (p_k <<< 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= (p_cur == PHASE_LAST) ? '0 : p_cur + PHASE_ONE;
		end
	end

	logic [SINE_BITS-2:0] rom_data;

	pwg_sine_rom #(
		.PHASE_STEPS(PHASE_STEPS),
		.SINE_BITS  (SINE_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (en1),
		.rd_addr(rom_addr),
		.rd_data(rom_data)
	);

	// stage 1
	logic [PW-1:0]        p_s1;
	logic                 neg_s1;
	logic                 sq_hi_s1;
	logic signed [KW-1:0] k_s1;
	logic signed [OW-1:0] opnd;
	logic signed [MW-1:0] mul_d;
	logic signed [OFFSET_W-1:0] amp_sx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1     <= p_cur;
			neg_s1   <= neg_d;
			sq_hi_s1 <= sq_hi_d;
			k_s1     <= KW'(k_d);
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_SINE, MODE_COSINE: opnd = OW'({1'b0, rom_data});
			default:                opnd = OW'(k_s1);
		endcase
		amp_sx = OFFSET_W'(amp_q);
		mul_d  = MW'(amp_sx) * MW'(opnd);
	end

	// stage 2: product
	logic [PW-1:0]        p_s2;
	logic                 neg_s2;
	logic                 sq_hi_s2;
	logic signed [MW-1:0] mul_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2     <= p_s1;
			neg_s2   <= neg_s1;
			sq_hi_s2 <= sq_hi_s1;
			mul_s2   <= mul_d;
		end
	end

	// stage 3: direct waveforms, numerator magnitude for the divide
	logic signed [YW-1:0]       y;
	logic                       y_neg_d;
	logic [XW-1:0]              yabs_d;
	logic [AMP_W-1:0]           smag;
	logic signed [SAMPLE_W-1:0] off_x;
	logic signed [SAMPLE_W-1:0] amp_x;
	logic signed [SAMPLE_W-1:0] mag_x;
	logic signed [SAMPLE_W-1:0] direct_d;

	always_comb begin
		y       = YW'(mul_s2) + on_q;
		y_neg_d = y[YW-1];
		yabs_d  = y_neg_d ? XW'(-y) : XW'(y);
		smag    = mul_s2[SINE_BITS-1 +: AMP_W];
		off_x   = SAMPLE_W'(off_q);
		amp_x   = SAMPLE_W'(amp_q);
		mag_x   = SAMPLE_W'(smag);
		unique case (mode_q)
			MODE_SINE, MODE_COSINE: direct_d = neg_s2 ? off_x - mag_x : off_x + mag_x;
			MODE_SQUARE:            direct_d = sq_hi_s2 ? off_x + amp_x : off_x - amp_x;
			default:                direct_d = '0;
		endcase
	end

	logic [PW-1:0]              p_s3;
	logic                       y_neg_s3;
	logic [XW-1:0]              yabs_s3;
	logic signed [SAMPLE_W-1:0] direct_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			p_s3      <= p_s2;
			y_neg_s3  <= y_neg_d;
			yabs_s3   <= yabs_d;
			direct_s3 <= direct_d;
		end
	end

	// stage 4: quotient estimate by reciprocal, low by at most one
	logic [PRW-1:0]             prod4;
	logic [PW-1:0]              p_s4;
	logic                       y_neg_s4;
	logic [XW-1:0]              yabs_s4;
	logic signed [SAMPLE_W-1:0] direct_s4;
	logic [QAW-1:0]             qa_s4;

	assign prod4 = PRW'(yabs_s3) * PRW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			p_s4      <= p_s3;
			y_neg_s4  <= y_neg_s3;
			yabs_s4   <= yabs_s3;
			direct_s4 <= direct_s3;
			qa_s4     <= prod4[Q30_SHIFT +: QAW];
		end
	end

	// stage 5: back-multiply
	logic [PW-1:0]              p_s5;
	logic                       y_neg_s5;
	logic [XW-1:0]              yabs_s5;
	logic signed [SAMPLE_W-1:0] direct_s5;
	logic [QAW-1:0]             qa_s5;
	logic [XW-1:0]              qan_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			p_s5      <= p_s4;
			y_neg_s5  <= y_neg_s4;
			yabs_s5   <= yabs_s4;
			direct_s5 <= direct_s4;
			qa_s5     <= qa_s4;
			qan_s5    <= XW'(qa_s4) * N_X;
		end
	end

	// correction, sign, final select into the output register
	logic [XW-1:0]              rem;
	logic [QAW-1:0]             quot;
	logic signed [SAMPLE_W-1:0] div_val;
	logic signed [SAMPLE_W-1:0] sample_d;

	always_comb begin
		rem     = yabs_s5 - qan_s5;
		quot    = (rem >= N_X) ? qa_s5 + QAW'(1) : qa_s5;
		div_val = y_neg_s5 ? -SAMPLE_W'(quot) : SAMPLE_W'(quot);
		unique case (mode_q)
			MODE_RAMP, MODE_TRIANGLE: sample_d = div_val;
			default:                  sample_d = direct_s5;
		endcase
	end

	logic [SAMPLE_W-1:0]    sample_q;
	logic [PHASE_OUT_W-1:0] pidx_q;
	logic                   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_o) begin
			out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			sample_q <= sample_d;
			pidx_q   <= PHASE_OUT_W'(p_s5);
			last_q   <= (p_s5 == PHASE_LAST);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_TDATA_W - SAMPLE_W - PHASE_OUT_W){1'b0}}, pidx_q, sample_q};
	assign m_tlast  = last_q;

	`PWG_ASSERT_NEXT(a_restart_phase, s_tvalid && s_tready && s_tdata[0], phase_q == PHASE_ONE, "restart tick did not advance to phase one")
	`PWG_ASSERT_NEXT(a_phase_wrap, s_tvalid && s_tready && !s_tdata[0] && phase_q == PHASE_LAST, phase_q == '0, "phase did not wrap after the last step")
	`PWG_ASSERT(a_full_stall, (out_v_q && !m_tready && v_s1 && v_s2 && v_s3 && v_s4 && v_s5) |-> !s_tready, "input taken while every stage is full and stalled")

endmodule

### verif/periodic_waveform_generator_core_test.sv
module periodic_waveform_generator_core_test;

	import pwg_pkg::*;

	localparam int PHASE_STEPS = 64;
	localparam int SINE_BITS   = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;
	localparam int STAGE_TICKS = 170;

	// codes with no member in the package enums
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG    = 2'd3;
	localparam logic [MODE_W-1:0]      MODE_UNUSED_6 = 3'd6;
	localparam logic [MODE_W-1:0]      MODE_UNUSED_7 = 3'd7;

	typedef struct {
		logic signed [SAMPLE_W-1:0]  sample;
		logic [PHASE_OUT_W-1:0]      phase_index;
		logic                        cycle_end;
	} wave_point_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;   // [0] restart
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;   // [16:0] sample, [22:17] phase_index
	logic                    m_tlast;   // cycle_end
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	bit           pending_ticks[$];
	wave_point_t  expected_points[$];
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	int unsigned  mismatches;
	int unsigned  quiet_cycles;
	bit           tick_done;

	// generator model state
	logic [MODE_W-1:0]  mode_reg;
	longint             amp_reg;
	longint             offset_reg;
	int unsigned        phase_pos;

	periodic_waveform_generator_core #(
		.PHASE_STEPS(PHASE_STEPS),
		.SINE_BITS(SINE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sin(2*pi*q/(4N)) in Q1.(SINE_BITS-1), quarter-wave folded, odd series in Q2.30
	function automatic longint sine_level(int unsigned q);
		int unsigned n;
		bit neg;
		logic [63:0] x, x2, t, s, m, lim;
		int i;
		n = PHASE_STEPS;
		neg = 1'b0;
		q = q % (4 * n);
		if (q >= 2 * n) begin
			q -= 2 * n;
			neg = 1'b1;
		end
		if (q > n)
			q = 2 * n - q;
		x = (PI_Q30 * 64'(q)) / 64'(2 * n);
		x2 = (x * x) >> Q30_SHIFT;
		t = ONE_Q30;
		for (i = 0; i < SERIES_TERMS; i++)
			t = ONE_Q30 - ((x2 * t) >> Q30_SHIFT) / 64'(SERIES_DIV[i]);
		s = (x * t) >> Q30_SHIFT;
		m = (s + (64'd1 << (30 - SINE_BITS))) >> (31 - SINE_BITS);
		lim = (64'd1 << (SINE_BITS - 1)) - 64'd1;
		if (m > lim)
			m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint wave_value(int unsigned p);
		longint n, pp, a, o, unit;
		n = PHASE_STEPS;
		pp = p;
		a = amp_reg;
		o = offset_reg;
		unit = longint'(1) << (SINE_BITS - 1);
		case (mode_reg)
			MODE_SINE:     return a * sine_level(4 * p) / unit + o;
			MODE_COSINE:   return a * sine_level(4 * p + PHASE_STEPS) / unit + o;
			MODE_SQUARE:   return (2 * pp <= n) ? a + o : o - a;
			MODE_RAMP:     return (o * n + a * (2 * pp - n)) / n;
			MODE_TRIANGLE: begin
				if (2 * pp <= n)
					return (o * n + a * (4 * pp - n)) / n;
				return (o * n + a * (3 * n - 4 * pp)) / n;
			end
			default:       return 0;
		endcase
	endfunction

	function automatic wave_point_t next_wave_point(bit restart);
		wave_point_t w;
		int unsigned p;
		if (restart)
			phase_pos = 0;
		p = phase_pos;
		w.sample = SAMPLE_W'(wave_value(p));
		w.phase_index = p[PHASE_OUT_W-1:0];
		w.cycle_end = (p == PHASE_STEPS - 1);
		phase_pos = (p + 1 >= PHASE_STEPS) ? 0 : p + 1;
		return w;
	endfunction

	// tick driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || tick_done)) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= {{(IN_TDATA_W-1){1'b0}}, pending_ticks.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: tracks register writes, predicts on tick transfers, checks sample transfers
	always @(posedge clk) begin
		wave_point_t want;
		if (arst_n) begin
			tick_done = s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WAVE_MODE:      mode_reg = cfg_data[MODE_W-1:0];
					CFG_PEAK_AMPLITUDE: amp_reg = cfg_data[AMP_W-1:0];
					CFG_DC_OFFSET:      offset_reg = $signed(cfg_data[OFFSET_W-1:0]);
					default: ;
				endcase
			end
			if (tick_done)
				expected_points.push_back(next_wave_point(s_tdata[0]));
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					$error("sample transfer with nothing expected: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (m_tdata[SAMPLE_W-1:0] !== want.sample) begin
						$error("sample: expected %0d, actual %0d", want.sample,
							$signed(m_tdata[SAMPLE_W-1:0]));
						mismatches++;
					end
					if (m_tdata[SAMPLE_W +: PHASE_OUT_W] !== want.phase_index) begin
						$error("phase_index: expected %0d, actual %0d", want.phase_index,
							m_tdata[SAMPLE_W +: PHASE_OUT_W]);
						mismatches++;
					end
					if (m_tlast !== want.cycle_end) begin
						$error("cycle_end: expected %0b, actual %0b", want.cycle_end, m_tlast);
						mismatches++;
					end
				end
			end
		end else begin
			tick_done = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("periodic_waveform_generator_core_test NOT OK");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_ticks.size() != 0 || s_tvalid || expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_wave(logic [CFG_DATA_W-1:0] mode_word,
			logic [CFG_DATA_W-1:0] amp_word, logic [CFG_DATA_W-1:0] offset_word);
		wait_drained();
		write_reg(CFG_WAVE_MODE, mode_word);
		write_reg(CFG_PEAK_AMPLITUDE, amp_word);
		write_reg(CFG_DC_OFFSET, offset_word);
	endtask

	task automatic push_ticks(int unsigned count, int unsigned restart_pct);
		repeat (count)
			pending_ticks.push_back($urandom_range(99) < restart_pct);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_word(logic [CFG_DATA_W-1:0] lo_end,
			logic [CFG_DATA_W-1:0] hi_end);
		case ($urandom_range(3))
			0:       return lo_end;
			1:       return hi_end;
			default: return CFG_DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int unsigned stage;
		int unsigned stage_ticks;
		int unsigned chunk;
		int unsigned restart_pct;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 30;
		recv_idle_pct = 81;
		mismatches = 0;
		mode_reg = MODE_ZERO;
		amp_reg = 0;
		offset_reg = 0;
		phase_pos = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);

		// sine, mode word with junk upper bits, both levels at full scale
		program_wave(16'hFFF8 | 16'(MODE_SINE), 16'h7FFF, 16'h7FFF);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b0);
		// cosine at phase 0 hits the clipped table peak; oversized amplitude word
		program_wave(16'(MODE_COSINE), 16'hFFFF, 16'h8000);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		program_wave(16'(MODE_SQUARE), 16'h7FFF, 16'h8000);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		program_wave(16'(MODE_RAMP), 16'h7FFF, 16'h7FFF);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		program_wave(16'(MODE_TRIANGLE), 16'h7FFF, 16'h0000);
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		program_wave(16'(MODE_UNUSED_6), 16'h1234, 16'h4000);
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b1);
		program_wave(16'(MODE_UNUSED_7), 16'h7FFF, 16'h8000);
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b0);
		// zero mode ignores the offset; write to a missing register is dropped
		program_wave(16'(MODE_ZERO), 16'h7FFF, 16'h7FFF);
		write_reg(CFG_NO_REG, 16'hFFFF);
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);

		for (stage = 0; stage < 3; stage++) begin
			wait_drained();
			case (stage)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			stage_ticks = 0;
			while (stage_ticks < STAGE_TICKS) begin
				program_wave(16'($urandom_range(0, 65535)), pick_word(16'h0000, 16'h7FFF),
					pick_word(16'h8000, 16'h7FFF));
				if ($urandom_range(3) == 0)
					write_reg(CFG_NO_REG, 16'($urandom_range(0, 65535)));
				case ($urandom_range(2))
					0:       restart_pct = 0;
					1:       restart_pct = 3;
					default: restart_pct = 25;
				endcase
				chunk = $urandom_range(20, 80);
				push_ticks(chunk, restart_pct);
				stage_ticks += chunk;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0)
			$display("periodic_waveform_generator_core_test OK");
		else
			$display("periodic_waveform_generator_core_test NOT OK");
		$finish;
	end

endmodule
